>>> rtl/nlr_pkg.sv
package nlr_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROUND,
        ST_ACC,
        ST_FINISH,
        ST_DPREP,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } nlr_state_t;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CLS_W   = 16;
    localparam int LP_W    = 24;
    localparam int WV_W    = 16;
    localparam int WT_W    = 17;
    localparam int PROD_W  = 41;
    localparam int SL_W    = 27;
    localparam int LSUM_W  = 41;
    localparam int LOSS_W  = 40;
    localparam int WSUM_W  = 32;
    localparam int DVD_W   = 55;
    localparam int CNT_W   = 6;
    localparam int FRAC_SHIFT = 14;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_SUM  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IGNORE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WEN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CLASSES = 2'd3;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [WT_W-1:0]   WEIGHT_ONE   = 17'd16384;
    localparam logic [PROD_W-1:0] RND_POS      = 41'd8192;
    localparam logic [PROD_W-1:0] RND_NEG      = 41'd8191;
    localparam logic [LOSS_W-1:0] LOUT_MAX     = {1'b0, {(LOSS_W-1){1'b1}}};
    localparam logic [LOSS_W-1:0] LOUT_MIN     = {1'b1, {(LOSS_W-1){1'b0}}};
    localparam logic [LSUM_W-1:0] LSUM_MAX     = {1'b0, {(LSUM_W-1){1'b1}}};
    localparam logic [LSUM_W-1:0] LSUM_MIN     = {1'b1, {(LSUM_W-1){1'b0}}};
    localparam logic [DVD_W-1:0]  QUO_POS_MAX  = DVD_W'(LOUT_MAX);
    localparam logic [DVD_W-1:0]  QUO_NEG_MAX  = DVD_W'(LOUT_MAX) + DVD_W'(1);

    localparam logic [1:0]  MODE_RESET    = MODE_MEAN;
    localparam logic [15:0] IGNORE_RESET  = 16'hFF9C;
    localparam logic [10:0] CLASSES_RESET = 11'd1024;

endpackage

>>> rtl/nll_loss_reduce.sv
// Weighted NLL loss with per-batch reduction.
// Input stream: tuser = func (0 weight write, 1 sample), tlast = batch end,
// tdata = class_index, log_prob, weight_value. Output stream: tdata = loss,
// weight_total; tuser = status (1 target out of range); tlast = batch end.
// Config: cfg_we/cfg_addr/cfg_data, registers mode, ignore class, weight
// enable, class count; write only while the block is idle.
// A weight write is taken in the idle state and gives no result.
// A sample passes from acceptance through multiply, round, accumulate, reduce
// and load to the output register (the table lookup happens at acceptance);
// in any mode but none, a sample that is not a batch end stops after reduce.
// Every stage runs on the one sequencer, so the next item is taken only back in idle.
// A batch end in mean mode with a nonzero total weight runs a restoring divider,
// one quotient bit per cycle over 55 bits, between a prepare and a saturate step.
// Out-of-range targets bypass the datapath and go from the check to the output.
// Reset clears accumulators and restores the register defaults; the weight
// table holds no reset value and must be written before it is used.
// A stalled receiver holds the result in the output register; the block
// keeps working on the next item and waits only to load a new result.
module nll_loss_reduce #(
    parameter int MAX_CLASSES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nlr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [nlr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // class_index[15:0], log_prob[39:16], weight_value[55:40]
    input  logic [nlr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // loss[39:0], weight_total[71:40]
    output logic [nlr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    import nlr_pkg::*;

    localparam int AW = $clog2(MAX_CLASSES);

    nlr_state_t state_reg, state_next;

    logic [1:0]              mode_reg, mode_next;
    logic [CLS_W-1:0]        ignore_reg, ignore_next;
    logic                    wen_reg, wen_next;
    logic [10:0]             classes_reg, classes_next;

    logic [CLS_W-1:0]        cls_reg, cls_next;
    logic signed [LP_W-1:0]  lp_reg, lp_next;
    logic                    last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [WT_W-1:0]         w_reg, w_next;
    logic signed [SL_W-1:0]  sl_reg, sl_next;
    logic [LSUM_W-1:0]       loss_sum_reg, loss_sum_next;
    logic [WSUM_W-1:0]       wsum_reg, wsum_next;
    logic [LOSS_W-1:0]       res_reg, res_next;
    logic                    err_reg, err_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [WSUM_W-1:0]       rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;
    logic                    m_user_reg, m_user_next;
    logic                    m_last_reg, m_last_next;

    logic                    in_accept;
    logic                    out_free;
    logic [CLS_W-1:0]        in_cls;
    logic                    in_cls_ok;
    logic                    ram_we;
    logic [WV_W-1:0]         ram_rdata;
    logic [15:0]             bound;
    logic                    is_ignored;
    logic                    is_oor;
    logic [WT_W-1:0]         w_sel;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] rnd_sum;
    logic [LSUM_W:0]         lsum_add;
    logic [WSUM_W:0]         wsum_add;
    logic [LSUM_W-1:0]       lsum_abs;
    logic [WSUM_W:0]         rem_shift;
    logic                    quo_bit;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign in_cls    = s_axis_tdata[CLS_W-1:0];
    assign in_cls_ok = !in_cls[CLS_W-1] && ({1'b0, in_cls[CLS_W-2:0]} < 16'(MAX_CLASSES));
    assign ram_we    = in_accept && (s_axis_tuser == FUNC_WEIGHT) && in_cls_ok;

    nlr_ram #(
        .WIDTH (WV_W),
        .DEPTH (MAX_CLASSES)
    ) u_weights (
        .clk   (clk),
        .we    (ram_we),
        .re    (in_accept),
        .addr  (in_cls[AW-1:0]),
        .wdata (s_axis_tdata[IN_DATA_W-1:CLS_W+LP_W]),
        .rdata (ram_rdata)
    );

    assign bound = ({5'b0, classes_reg} < 16'(MAX_CLASSES)) ? {5'b0, classes_reg}
                                                            : 16'(MAX_CLASSES);
    assign is_ignored = (cls_reg == ignore_reg);
    assign is_oor     = cls_reg[CLS_W-1] || ({1'b0, cls_reg[CLS_W-2:0]} >= bound);
    assign w_sel      = wen_reg ? {1'b0, ram_rdata} : WEIGHT_ONE;
    assign prod_c     = lp_reg * $signed({1'b0, w_sel});
    assign rnd_sum    = prod_reg + $signed(prod_reg[PROD_W-1] ? RND_NEG : RND_POS);
    assign lsum_add   = {loss_sum_reg[LSUM_W-1], loss_sum_reg} + (LSUM_W+1)'(sl_reg);
    assign wsum_add   = {1'b0, wsum_reg} + (WSUM_W+1)'(w_reg);
    assign lsum_abs   = loss_sum_reg[LSUM_W-1] ? (~loss_sum_reg + LSUM_W'(1)) : loss_sum_reg;
    assign rem_shift  = {rem_reg, dvd_reg[DVD_W-1]};
    assign quo_bit    = (rem_shift >= {1'b0, wsum_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == FUNC_SAMPLE))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (is_ignored)
                begin
                    state_next = ST_FINISH;
                end
                else if (is_oor)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (mode_reg == MODE_NONE)
                begin
                    state_next = ST_OUT;
                end
                else if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if ((mode_reg == MODE_MEAN) && (wsum_reg != '0))
                begin
                    state_next = ST_DPREP;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DPREP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next     = mode_reg;
        ignore_next   = ignore_reg;
        wen_next      = wen_reg;
        classes_next  = classes_reg;
        cls_next      = cls_reg;
        lp_next       = lp_reg;
        last_next     = last_reg;
        prod_next     = prod_reg;
        w_next        = w_reg;
        sl_next       = sl_reg;
        loss_sum_next = loss_sum_reg;
        wsum_next     = wsum_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        s_axis_tready = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:    mode_next    = cfg_data[1:0];
                REG_IGNORE:  ignore_next  = cfg_data;
                REG_WEN:     wen_next     = cfg_data[0];
                REG_CLASSES: classes_next = cfg_data[10:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cls_next      = in_cls;
                lp_next       = s_axis_tdata[CLS_W+LP_W-1:CLS_W];
                last_next     = s_axis_tlast;
            end
            ST_CHECK:
            begin
                err_next  = STATUS_OK;
                sl_next   = '0;
                prod_next = prod_c;
                w_next    = w_sel;
                if (!is_ignored && is_oor)
                begin
                    err_next = STATUS_RANGE;
                    res_next = '0;
                end
            end
            ST_ROUND:
            begin
                sl_next = -$signed(rnd_sum[PROD_W-1:FRAC_SHIFT]);
            end
            ST_ACC:
            begin
                if (lsum_add[LSUM_W] != lsum_add[LSUM_W-1])
                begin
                    loss_sum_next = lsum_add[LSUM_W] ? LSUM_MIN : LSUM_MAX;
                end
                else
                begin
                    loss_sum_next = lsum_add[LSUM_W-1:0];
                end
                wsum_next = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
            end
            ST_FINISH:
            begin
                neg_next = loss_sum_reg[LSUM_W-1];
                dvd_next = {lsum_abs, {FRAC_SHIFT{1'b0}}};
                case (mode_reg)
                    MODE_NONE: res_next = LOSS_W'(sl_reg);
                    default:
                    begin
                        if (loss_sum_reg[LSUM_W-1] != loss_sum_reg[LSUM_W-2])
                        begin
                            res_next = loss_sum_reg[LSUM_W-1] ? LOUT_MIN : LOUT_MAX;
                        end
                        else
                        begin
                            res_next = loss_sum_reg[LOSS_W-1:0];
                        end
                    end
                endcase
            end
            ST_DPREP:
            begin
                dvd_next = dvd_reg + DVD_W'(wsum_reg >> 1);
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                rem_next = quo_bit ? WSUM_W'(rem_shift - {1'b0, wsum_reg})
                                   : rem_shift[WSUM_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], quo_bit};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_SAT:
            begin
                if (neg_reg)
                begin
                    res_next = (dvd_reg > QUO_NEG_MAX) ? LOUT_MIN
                                                       : (~dvd_reg[LOSS_W-1:0] + LOSS_W'(1));
                end
                else
                begin
                    res_next = (dvd_reg > QUO_POS_MAX) ? LOUT_MAX : dvd_reg[LOSS_W-1:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(err_reg ? {WSUM_W{1'b0}} : wsum_reg), res_reg};
                    m_user_next  = err_reg;
                    m_last_next  = last_reg;
                    if (err_reg || last_reg)
                    begin
                        loss_sum_next = '0;
                        wsum_next     = '0;
                    end
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_RESET;
            ignore_reg   <= IGNORE_RESET;
            wen_reg      <= 1'b0;
            classes_reg  <= CLASSES_RESET;
            loss_sum_reg <= '0;
            wsum_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            ignore_reg   <= ignore_next;
            wen_reg      <= wen_next;
            classes_reg  <= classes_next;
            loss_sum_reg <= loss_sum_next;
            wsum_reg     <= wsum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        lp_reg     <= lp_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        w_reg      <= w_next;
        sl_reg     <= sl_next;
        res_reg    <= res_next;
        err_reg    <= err_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_RANGE)) |-> (m_axis_tdata == '0))
        else $error("range error result carries nonzero payload");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free && (err_reg || last_reg))
        |=> ((loss_sum_reg == '0) && (wsum_reg == '0)))
        else $error("accumulators not cleared after batch end");

    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (wsum_reg != '0))
        else $error("divide with zero total weight");

    a_ram_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("weight table written while busy");
`endif

endmodule

>>> rtl/nlr_ram.sv
module nlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> dv/nll_loss_reduce_chk.sv
`timescale 1ns / 100ps

module nll_loss_reduce_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nlr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nlr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [nlr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [nlr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             fail_count,
    output int                             pending
);

    import nlr_pkg::*;

    localparam int     NUM_CLASSES = 1024;
    localparam longint LSUM_HI     = longint'($signed(LSUM_MAX));
    localparam longint LSUM_LO     = longint'($signed(LSUM_MIN));
    localparam longint LOUT_HI     = longint'($signed(LOUT_MAX));
    localparam longint LOUT_LO     = longint'($signed(LOUT_MIN));
    localparam longint WSUM_TOP    = longint'({WSUM_W{1'b1}});
    localparam longint FRAC_ONE    = longint'(1) << FRAC_SHIFT;

    typedef struct packed {
        logic [LOSS_W-1:0] loss;
        logic [WSUM_W-1:0] weight_total;
        logic              status;
        logic              last;
    } nll_result_t;

    logic [WV_W-1:0] weight_tab [NUM_CLASSES];
    longint          loss_acc;
    longint          weight_acc;
    logic [1:0]      mode_r;
    longint          ignore_r;
    logic            wen_r;
    logic [10:0]     classes_r;
    nll_result_t     loss_q [$];

    initial fail_count = 0;
    initial pending = 0;

    // round to nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void predict_loss(input logic func, input logic [IN_DATA_W-1:0] data,
                                         input logic last);
        longint      cls;
        longint      lp;
        longint      w;
        longint      bound;
        longint      sample_loss;
        longint      reduced;
        nll_result_t res;
        cls = longint'($signed(data[CLS_W-1:0]));
        lp = longint'($signed(data[CLS_W +: LP_W]));
        bound = (classes_r < NUM_CLASSES) ? longint'(classes_r) : longint'(NUM_CLASSES);
        sample_loss = 0;
        if (func == FUNC_WEIGHT)
        begin
            if (cls >= 0 && cls < NUM_CLASSES)
                weight_tab[cls] = data[IN_DATA_W-1 -: WV_W];
            return;
        end
        if (cls != ignore_r)
        begin
            if (cls < 0 || cls >= bound)
            begin
                loss_acc = 0;
                weight_acc = 0;
                res.loss = '0;
                res.weight_total = '0;
                res.status = STATUS_RANGE;
                res.last = last;
                loss_q.push_back(res);
                return;
            end
            w = wen_r ? longint'(weight_tab[cls]) : longint'(WEIGHT_ONE);
            sample_loss = round_div(-(lp * w), FRAC_ONE);
            loss_acc = clamp(loss_acc + sample_loss, LSUM_LO, LSUM_HI);
            weight_acc = (weight_acc + w > WSUM_TOP) ? WSUM_TOP : weight_acc + w;
        end
        if (mode_r == MODE_NONE)
            reduced = sample_loss;
        else if (!last)
            return;
        else if (mode_r == MODE_MEAN && weight_acc != 0)
            reduced = round_div(loss_acc * FRAC_ONE, weight_acc);
        else
            reduced = loss_acc;
        res.loss = LOSS_W'(clamp(reduced, LOUT_LO, LOUT_HI));
        res.weight_total = WSUM_W'(weight_acc);
        res.status = STATUS_OK;
        res.last = last;
        loss_q.push_back(res);
        if (last)
        begin
            loss_acc = 0;
            weight_acc = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        nll_result_t       head;
        logic [LOSS_W-1:0] got_loss;
        logic [WSUM_W-1:0] got_weight;
        if (!rst_n)
        begin
            mode_r = MODE_RESET;
            ignore_r = longint'($signed(IGNORE_RESET));
            wen_r = 1'b0;
            classes_r = CLASSES_RESET;
            loss_acc = 0;
            weight_acc = 0;
            loss_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MODE:    mode_r = cfg_data[1:0];
                    REG_IGNORE:  ignore_r = longint'($signed(cfg_data));
                    REG_WEN:     wen_r = cfg_data[0];
                    REG_CLASSES: classes_r = cfg_data[10:0];
                    default:     ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_loss(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_loss = m_axis_tdata[LOSS_W-1:0];
                got_weight = m_axis_tdata[LOSS_W +: WSUM_W];
                if (loss_q.size() == 0)
                begin
                    $error("unexpected transaction: loss %0d weight_total %0d",
                           $signed(got_loss), got_weight);
                    fail_count++;
                end
                else
                begin
                    head = loss_q.pop_front();
                    if (got_loss !== head.loss)
                    begin
                        $error("loss: expected %0d, got %0d", $signed(head.loss),
                               $signed(got_loss));
                        fail_count++;
                    end
                    if (got_weight !== head.weight_total)
                    begin
                        $error("weight_total: expected %0d, got %0d", head.weight_total,
                               got_weight);
                        fail_count++;
                    end
                    if (m_axis_tuser !== head.status)
                    begin
                        $error("status: expected %0d, got %0d", head.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tlast !== head.last)
                    begin
                        $error("last: expected %0d, got %0d", head.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            pending <= loss_q.size();
        end
    end

endmodule

>>> dv/nll_loss_reduce_tb.sv
`timescale 1ns / 100ps

module nll_loss_reduce_tb;
    import nlr_pkg::*;

    localparam int         NUM_CLASSES     = 1024;
    localparam int         ITEMS_PER_PHASE = 205;
    localparam int         DRAIN_CYCLES    = 80;
    localparam int         HOLD_CYCLES     = 500;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam logic [1:0] MODE_SUM_ALT    = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // class_index, log_prob, weight_value
    logic                  s_axis_tuser = 1'b0; // func
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // loss, weight_total
    logic                  m_axis_tuser;        // status
    logic                  m_axis_tlast;

    int                    fail_count;
    int                    pending;
    int                    src_idle = 0;
    int                    sink_idle = 0;
    logic                  hold_req = 1'b0;
    int                    hold_left = 0;
    int                    cycles = 0;
    bit                    written [NUM_CLASSES];

    logic [1:0]            cur_mode = MODE_RESET;
    logic signed [15:0]    cur_ignore = IGNORE_RESET;
    logic                  cur_wen = 1'b0;
    logic [10:0]           cur_classes = CLASSES_RESET;

    always #10 clk = ~clk;

    nll_loss_reduce u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    nll_loss_reduce_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("nll_loss_reduce: mismatch");
            $finish;
        end
    end

    function automatic int cls_bound();
        return (cur_classes < NUM_CLASSES) ? int'(cur_classes) : NUM_CLASSES;
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return WV_W'(WEIGHT_ONE);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic func, input logic signed [15:0] cls,
                             input logic [23:0] lp, input logic [15:0] wv, input logic last);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {wv, lp, cls};
        s_axis_tuser <= func;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (func == FUNC_WEIGHT && cls >= 0 && cls < NUM_CLASSES)
            written[cls] = 1'b1;
    endtask

    // a weight lookup must never hit an unwritten entry
    task automatic send_sample(input logic signed [15:0] cls, input logic [23:0] lp,
                               input logic last, inout int sent);
        if (cur_wen && cls != cur_ignore && cls >= 0 && cls < cls_bound() && !written[cls])
        begin
            send_item(FUNC_WEIGHT, cls, 24'($urandom), pick_weight(), 1'($urandom));
            sent++;
        end
        send_item(FUNC_SAMPLE, cls, lp, 16'($urandom), last);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic signed [15:0] ign,
                              input logic wen, input logic [10:0] classes);
        drain();
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_IGNORE, ign);
        write_reg(REG_WEN, CFG_DATA_W'(wen));
        write_reg(REG_CLASSES, CFG_DATA_W'(classes));
        cur_mode = mode;
        cur_ignore = ign;
        cur_wen = wen;
        cur_classes = classes;
    endtask

    task automatic run_phase(input int n_items);
        int                 sent;
        int                 blen;
        int                 r;
        int                 bound;
        logic signed [15:0] cls;
        logic [23:0]        lp;
        sent = 0;
        bound = cls_bound();
        while (sent < n_items)
        begin
            blen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            for (int k = 0; k < blen; k++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    cls = ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(NUM_CLASSES - 1));
                    send_item(FUNC_WEIGHT, cls, 24'($urandom), pick_weight(), 1'($urandom));
                    sent++;
                end
                r = $urandom_range(99);
                if (r < 65 && bound > 0)
                    cls = 16'($urandom_range(bound - 1));
                else if (r < 75)
                    cls = cur_ignore;
                else if (r < 85)
                    cls = $urandom_range(1) ? 16'(-1 - int'($urandom_range(3)))
                                            : 16'(bound + int'($urandom_range(3)));
                else
                    cls = 16'($urandom);
                r = $urandom_range(99);
                if (r < 40)
                    lp = 24'(-int'($urandom_range(1 << 20)));
                else if (r < 60)
                    lp = 24'($urandom);
                else if (r < 70)
                begin
                    case ($urandom_range(3))
                        0:       lp = 24'h800000;
                        1:       lp = 24'h7FFFFF;
                        2:       lp = 24'h000000;
                        default: lp = 24'hFFFFFF;
                    endcase
                end
                else
                    lp = 24'($urandom_range(1024)) - 24'd512;
                send_sample(cls, lp, k == blen - 1, sent);
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: per-sample losses, weight table extremes, rounding ties
        set_config(MODE_NONE, -16'sd100, 1'b1, 11'd1024);
        send_item(FUNC_WEIGHT, 16'sd0, 24'h0, 16'd16384, 1'b0);
        send_item(FUNC_WEIGHT, 16'sd1023, 24'h0, 16'hFFFF, 1'b1);
        send_item(FUNC_WEIGHT, 16'sd5, 24'h0, 16'd8192, 1'b0);
        send_item(FUNC_WEIGHT, 16'sd6, 24'h0, 16'd0, 1'b0);
        send_item(FUNC_WEIGHT, -16'sd1, 24'h0, 16'd1, 1'b0);
        send_item(FUNC_WEIGHT, 16'sd1024, 24'h0, 16'd1, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd0, 24'h800000, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd1023, 24'h7FFFFF, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd5, 24'h000001, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd5, 24'hFFFFFF, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd6, 24'(-777), 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, -16'sd100, 24'hFFFFFF, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sh8000, 24'h123456, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sh7FFF, 24'h654321, 16'd0, 1'b1);

        // mean, out-of-range at count boundary, zero total weight
        set_config(MODE_MEAN, -16'sd100, 1'b0, 11'd4);
        send_item(FUNC_SAMPLE, 16'sd3, 24'(-100000), 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd2, 24'(-5), 16'd0, 1'b1);
        send_item(FUNC_SAMPLE, 16'sd4, 24'(-5), 16'd0, 1'b1);
        send_item(FUNC_SAMPLE, -16'sd100, 24'(-5), 16'd0, 1'b1);

        set_config(MODE_SUM_ALT, 16'sh7FFF, 1'b1, 11'd2047);
        send_item(FUNC_SAMPLE, 16'sd1023, 24'h7FFFFF, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sd0, 24'h800000, 16'd0, 1'b0);
        send_item(FUNC_SAMPLE, 16'sh7FFF, 24'd5, 16'd0, 1'b1);

        set_config(MODE_SUM, 16'sh8000, 1'b0, 11'd0);
        send_item(FUNC_SAMPLE, 16'sd0, 24'(-9), 16'd0, 1'b1);
        send_item(FUNC_SAMPLE, 16'sh8000, 24'(-9), 16'd0, 1'b1);

        src_idle = 15;
        sink_idle <= 57;
        set_config(MODE_NONE, 16'sh8000, 1'b1, 11'd1);
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_MEAN, 16'sh7FFF, 1'b1, 11'd16);
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_SUM, 16'sd3, 1'b0, 11'd2047);
        run_phase(ITEMS_PER_PHASE);

        src_idle = 57;
        sink_idle <= 15;
        set_config(MODE_SUM_ALT, 16'sd0, 1'b1, 11'd1024);
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_MEAN, -16'sd100, 1'b0, 11'd0);
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_NONE, 16'($urandom), 1'b1, 11'd200);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        run_phase(ITEMS_PER_PHASE);

        src_idle = 0;
        sink_idle <= 0;
        set_config(MODE_MEAN, 16'sd7, 1'b1, 11'd8);
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_SUM, 16'($urandom), 1'b1, 11'($urandom_range(1, 2047)));
        run_phase(ITEMS_PER_PHASE);
        set_config(MODE_MEAN, -16'sd1, 1'b1, 11'd1024);
        run_phase(ITEMS_PER_PHASE);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("nll_loss_reduce: match");
        else
            $display("nll_loss_reduce: mismatch");
        $finish;
    end

endmodule
